// File: rtl/pmps_pkg.sv
// Package for the point motor pulse sequencer: codes, register indexes,
// configuration and result types, and the LED lookup. No dependencies.
package pmps_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_TICKS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_BLINK_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_END_TICK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_START_TICK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_END_TICK   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_END_TICK   = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [15:0] LOCK_TICKS_RST       = 16'd3000;
    localparam logic [7:0]  LOCK_BLINK_TICKS_RST = 8'd63;
    localparam logic [15:0] BLINK_END_TICK_RST   = 16'd1000;
    localparam logic [15:0] PULSE_START_TICK_RST = 16'd1001;
    localparam logic [15:0] PULSE_END_TICK_RST   = 16'd1250;
    localparam logic [15:0] CYCLE_END_TICK_RST   = 16'd2000;

    // Item function codes.
    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_REQUEST = 2'd1;
    localparam logic [1:0] FUNC_LOCK    = 2'd2;

    // Position codes.
    localparam logic [1:0] POS_NONE   = 2'd0;
    localparam logic [1:0] POS_CLOSED = 2'd1;
    localparam logic [1:0] POS_THROWN = 2'd2;

    // LED and coil bit masks.
    localparam logic [1:0] LED_CLOSED  = 2'b01;
    localparam logic [1:0] LED_THROWN  = 2'b10;
    localparam logic [2:0] COIL_COMMON = 3'b001;
    localparam logic [2:0] COIL_CLOSE  = 3'b010;
    localparam logic [2:0] COIL_THROW  = 3'b100;

    // The move LED toggles when the low seven sequence bits are all ones, before the blink end tick.
    localparam logic [6:0] MOVE_BLINK_MASK = 7'h7F;

    typedef struct packed {
        logic [15:0] lock_ticks;
        logic [7:0]  lock_blink_ticks;
        logic [15:0] blink_end_tick;
        logic [15:0] pulse_start_tick;
        logic [15:0] pulse_end_tick;
        logic [15:0] cycle_end_tick;
    } t_cfg;

    typedef struct packed {
        logic       led_closed;
        logic       led_thrown;
        logic       coil_common;
        logic       coil_close;
        logic       coil_throw;
        logic [1:0] shown_position;
        logic       busy_res;
        logic       locked;
    } t_result;

    function automatic logic [1:0] led_of(input logic [1:0] pos);
        logic [1:0] led;
        unique case (pos)
            POS_CLOSED: led = LED_CLOSED;
            POS_THROWN: led = LED_THROWN;
            default:    led = 2'b00;
        endcase
        return led;
    endfunction

endpackage

// File: rtl/pmps_in_if.sv
// Input channel of the point motor pulse sequencer: valid/ready plus one item.
// Depends on nothing.
interface pmps_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [1:0] direction;

    modport source (output valid, output func, output direction, input ready);
    modport sink   (input valid, input func, input direction, output ready);
endinterface

// File: rtl/pmps_out_if.sv
// Result channel of the point motor pulse sequencer: valid/ready plus pin levels.
// Depends on nothing.
interface pmps_out_if;
    logic       valid;
    logic       ready;
    logic       led_closed;
    logic       led_thrown;
    logic       coil_common;
    logic       coil_close;
    logic       coil_throw;
    logic [1:0] shown_position;
    logic       busy_res;
    logic       locked;

    modport source (output valid, output led_closed, output led_thrown,
                    output coil_common, output coil_close, output coil_throw,
                    output shown_position, output busy_res, output locked,
                    input ready);
    modport sink   (input valid, input led_closed, input led_thrown,
                    input coil_common, input coil_close, input coil_throw,
                    input shown_position, input busy_res, input locked,
                    output ready);
endinterface

// File: rtl/pmps_cfg.sv
// Configuration register file of the point motor pulse sequencer.
// Depends on pmps_pkg.
module pmps_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pmps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pmps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output pmps_pkg::t_cfg                 o_cfg
);
    import pmps_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LOCK_TICKS:       n_cfg.lock_ticks       = i_cfg_data;
                CFG_LOCK_BLINK_TICKS: n_cfg.lock_blink_ticks = i_cfg_data[7:0];
                CFG_BLINK_END_TICK:   n_cfg.blink_end_tick   = i_cfg_data;
                CFG_PULSE_START_TICK: n_cfg.pulse_start_tick = i_cfg_data;
                CFG_PULSE_END_TICK:   n_cfg.pulse_end_tick   = i_cfg_data;
                CFG_CYCLE_END_TICK:   n_cfg.cycle_end_tick   = i_cfg_data;
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lock_ticks       <= LOCK_TICKS_RST;
            r_cfg.lock_blink_ticks <= LOCK_BLINK_TICKS_RST;
            r_cfg.blink_end_tick   <= BLINK_END_TICK_RST;
            r_cfg.pulse_start_tick <= PULSE_START_TICK_RST;
            r_cfg.pulse_end_tick   <= PULSE_END_TICK_RST;
            r_cfg.cycle_end_tick   <= CYCLE_END_TICK_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/pmps_core.sv
// Sequencer state and its one-pass update for a single item; the result
// reflects the state after the item. Depends on pmps_pkg.
module pmps_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [1:0]          i_func,
    input  logic [1:0]          i_direction,
    input  pmps_pkg::t_cfg      i_cfg,
    output pmps_pkg::t_result   o_res
);
    import pmps_pkg::*;

    logic [15:0] r_seq,   n_seq;
    logic [15:0] r_lock,  n_lock;
    logic [7:0]  r_lbc,   n_lbc;
    logic [1:0]  r_am,    n_am;
    logic [1:0]  r_pend,  n_pend;
    logic [1:0]  r_pos,   n_pos;
    logic [1:0]  r_led,   n_led;
    logic [2:0]  r_coil,  n_coil;

    always_comb begin
        logic        v_start;
        logic [15:0] v_seq;
        logic [1:0]  v_bit;
        logic        v_inc;

        n_seq  = r_seq;
        n_lock = r_lock;
        n_lbc  = r_lbc;
        n_am   = r_am;
        n_pend = r_pend;
        n_pos  = r_pos;
        n_led  = r_led;
        n_coil = r_coil;
        v_start = 1'b0;
        v_seq   = r_seq;
        v_bit   = 2'b00;
        v_inc   = 1'b1;

        if (i_en) begin
            unique case (i_func)
                FUNC_TICK: begin
                    // Lockout runs first; the sequence sees the updated count.
                    if (r_lock != 16'd0) begin
                        n_lock = r_lock - 16'd1;
                        if (n_lock == 16'd0) begin
                            n_led = n_led | led_of(r_pos);
                            n_lbc = 8'd0;
                        end else begin
                            n_lbc = r_lbc + 8'd1;
                            if (n_lbc == i_cfg.lock_blink_ticks) begin
                                n_led = n_led ^ led_of(r_pos);
                                n_lbc = 8'd0;
                            end
                        end
                    end

                    v_start = (r_seq == 16'd0) && (r_pend != POS_NONE) && (n_lock == 16'd0);
                    if (v_start) begin
                        n_am   = r_pend;
                        n_pos  = r_pend;
                        n_pend = POS_NONE;
                        v_seq  = 16'd1;
                    end

                    if (r_seq != 16'd0 || v_start) begin
                        v_bit = led_of(n_am);
                        priority if (v_seq == 16'd1) begin
                            if (v_bit == 2'b00) begin
                                n_am  = POS_NONE;
                                v_inc = 1'b0;
                            end else begin
                                n_led = v_bit;
                            end
                        end else if (v_seq < i_cfg.blink_end_tick) begin
                            if (v_seq[6:0] == MOVE_BLINK_MASK && v_bit != 2'b00) begin
                                n_led = (n_led ^ v_bit) & v_bit;
                            end
                        end else if (v_seq == i_cfg.pulse_start_tick) begin
                            if (v_bit == 2'b00) begin
                                n_am  = POS_NONE;
                                v_inc = 1'b0;
                            end else begin
                                n_coil = n_coil | COIL_COMMON |
                                         ((n_am == POS_CLOSED) ? COIL_CLOSE : COIL_THROW);
                                n_led  = v_bit;
                                n_am   = POS_NONE;
                            end
                        end else if (v_seq == i_cfg.pulse_end_tick) begin
                            n_coil = 3'b000;
                        end else if (v_seq >= i_cfg.cycle_end_tick) begin
                            // A move that never reached its pulse starts over.
                            v_inc = 1'b0;
                        end else begin
                            v_inc = 1'b1;
                        end

                        if (v_inc) begin
                            n_seq = v_seq + 16'd1;
                        end else if (v_seq >= i_cfg.cycle_end_tick && v_seq != 16'd1
                                     && v_seq >= i_cfg.blink_end_tick
                                     && v_seq != i_cfg.pulse_start_tick
                                     && v_seq != i_cfg.pulse_end_tick
                                     && n_am != POS_NONE) begin
                            n_seq = 16'd1;
                        end else begin
                            n_seq = 16'd0;
                        end
                    end
                end
                FUNC_REQUEST: n_pend = i_direction;
                FUNC_LOCK:    n_lock = i_cfg.lock_ticks;
                default: begin
                    n_seq = r_seq;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq  <= 16'd0;
            r_lock <= 16'd0;
            r_lbc  <= 8'd0;
            r_am   <= POS_NONE;
            r_pend <= POS_NONE;
            r_pos  <= POS_NONE;
            r_led  <= 2'b00;
            r_coil <= 3'b000;
        end else begin
            r_seq  <= n_seq;
            r_lock <= n_lock;
            r_lbc  <= n_lbc;
            r_am   <= n_am;
            r_pend <= n_pend;
            r_pos  <= n_pos;
            r_led  <= n_led;
            r_coil <= n_coil;
        end
    end

    assign o_res.led_closed     = n_led[0];
    assign o_res.led_thrown     = n_led[1];
    assign o_res.coil_common    = n_coil[0];
    assign o_res.coil_close     = n_coil[1];
    assign o_res.coil_throw     = n_coil[2];
    assign o_res.shown_position = n_pos;
    assign o_res.busy_res       = (n_seq != 16'd0);
    assign o_res.locked         = (n_lock != 16'd0);

endmodule

// File: rtl/point_motor_pulse_sequencer_top.sv
// Point motor pulse sequencer: one result word per input word.
// The result word passes through the input register, then the result register.
// Throughput: one word per cycle unless the result channel stalls; the state update
// sits between the two registers.
// Reset is synchronous and active low: state, handshake and configuration registers
// return to their defaults, with no clearing pass.
// Depends on pmps_pkg, pmps_in_if, pmps_out_if, pmps_cfg and pmps_core.
module point_motor_pulse_sequencer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pmps_in_if.sink                        i_item,
    pmps_out_if.source                     o_res,
    input  logic                           i_cfg_we,
    input  logic [pmps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pmps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pmps_pkg::*;

    logic       r_in_valid;
    logic [1:0] r_func;
    logic [1:0] r_dir;
    logic       r_out_valid;
    t_result    r_res;
    t_cfg       w_cfg;
    t_result    w_res;
    logic       w_adv;

    // A held word moves into the result register when that register is free
    // or is being emptied in the same cycle.
    assign w_adv        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_item.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_func <= i_item.func;
            r_dir  <= i_item.direction;
        end
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    pmps_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    pmps_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_adv),
        .i_func      (r_func),
        .i_direction (r_dir),
        .i_cfg       (w_cfg),
        .o_res       (w_res)
    );

    assign o_res.valid          = r_out_valid;
    assign o_res.led_closed     = r_res.led_closed;
    assign o_res.led_thrown     = r_res.led_thrown;
    assign o_res.coil_common    = r_res.coil_common;
    assign o_res.coil_close     = r_res.coil_close;
    assign o_res.coil_throw     = r_res.coil_throw;
    assign o_res.shown_position = r_res.shown_position;
    assign o_res.busy_res       = r_res.busy_res;
    assign o_res.locked         = r_res.locked;

endmodule

// File: rtl/pmps_checker.sv
// Port-level checks for the point motor pulse sequencer, bound to its top level.
// Depends on point_motor_pulse_sequencer_top.
module pmps_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_coil_common,
    input logic       i_coil_close,
    input logic       i_coil_throw,
    input logic [1:0] i_shown_position
);

    // A result word that is stalled stays offered with the same coil levels.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_coil_common) && $stable(i_coil_close)
            && $stable(i_coil_throw) && $stable(i_shown_position))
        else $error("stalled result word changed");

    // A direction coil is only ever driven together with the common coil.
    a_coil_common: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_coil_close || i_coil_throw) |-> i_coil_common)
        else $error("direction coil driven without common coil");

    // Reset empties the result register.
    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind point_motor_pulse_sequencer_top pmps_checker u_pmps_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_coil_common    (o_res.coil_common),
    .i_coil_close     (o_res.coil_close),
    .i_coil_throw     (o_res.coil_throw),
    .i_shown_position (o_res.shown_position)
);
